// ===== rtl/erf_pkg.sv =====
// Shared constants, types and state encoding for the extreme row finder.
package erf_pkg;

   localparam int MAX_COLUMNS = 8;
   localparam int MAX_ROWS    = 1024;
   localparam int COL_W       = $clog2(MAX_COLUMNS);
   localparam int ROW_W       = 11;
   localparam int VAL_W       = 32;
   localparam int CFG_W       = 4;
   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(MAX_COLUMNS);

   typedef struct packed {
      logic load;     // first valid row of the set: take the value everywhere
      logic min_we;   // this lane takes the row as new minimum holder
      logic max_we;   // this lane takes the row as new maximum holder
   } lane_ctrl_type;

   typedef struct packed {
      logic lt;       // incoming value strictly below held minimum
      logic gt;       // incoming value strictly above held maximum
   } lane_flag_type;

   typedef enum logic {
      ST_ROWS,
      ST_EMIT
   } state_type;

endpackage

// ===== rtl/erf_if.sv =====
// Valid/ready channel interfaces for rows, results and the column register.
interface erf_req_if;
   logic                           valid;
   logic                           ready;
   logic                           row_valid;
   logic signed [erf_pkg::VAL_W-1:0] value_0;
   logic signed [erf_pkg::VAL_W-1:0] value_1;
   logic signed [erf_pkg::VAL_W-1:0] value_2;
   logic signed [erf_pkg::VAL_W-1:0] value_3;
   logic signed [erf_pkg::VAL_W-1:0] value_4;
   logic signed [erf_pkg::VAL_W-1:0] value_5;
   logic signed [erf_pkg::VAL_W-1:0] value_6;
   logic signed [erf_pkg::VAL_W-1:0] value_7;
   logic                           last_row;

   modport source (output valid, row_valid, value_0, value_1, value_2, value_3,
                   value_4, value_5, value_6, value_7, last_row, input ready);
   modport sink   (input valid, row_valid, value_0, value_1, value_2, value_3,
                   value_4, value_5, value_6, value_7, last_row, output ready);
endinterface

interface erf_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [erf_pkg::COL_W-1:0]  column_index;
   logic [erf_pkg::ROW_W-1:0]  min_row;
   logic [erf_pkg::ROW_W-1:0]  max_row;
   logic                       last_result;

   modport source (output valid, column_index, min_row, max_row, last_result,
                   input ready);
   modport sink   (input valid, column_index, min_row, max_row, last_result,
                   output ready);
endinterface

interface erf_csr_if;
   logic                       valid;
   logic                       ready;
   logic [erf_pkg::CFG_W-1:0]  data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/erf_lane.sv =====
// One column lane: held extremes, their holder rows and the strict compares.
module erf_lane (
   input  logic                                clock,
   input  logic signed [erf_pkg::VAL_W-1:0]    value,
   input  logic        [erf_pkg::ROW_W-1:0]    row,
   input  erf_pkg::lane_ctrl_type              ctrl,
   output erf_pkg::lane_flag_type              flag,
   output logic        [erf_pkg::ROW_W-1:0]    min_holder,
   output logic        [erf_pkg::ROW_W-1:0]    max_holder
);

   logic signed [erf_pkg::VAL_W-1:0] min_value_ff, min_value_in;
   logic signed [erf_pkg::VAL_W-1:0] max_value_ff, max_value_in;
   logic        [erf_pkg::ROW_W-1:0] min_holder_ff, min_holder_in;
   logic        [erf_pkg::ROW_W-1:0] max_holder_ff, max_holder_in;

   assign flag.lt = value < min_value_ff;
   assign flag.gt = value > max_value_ff;

   always_comb begin
      min_value_in  = min_value_ff;
      max_value_in  = max_value_ff;
      min_holder_in = min_holder_ff;
      max_holder_in = max_holder_ff;
      if (ctrl.load || ctrl.min_we) begin
         min_value_in  = value;
         min_holder_in = row;
      end
      if (ctrl.load || ctrl.max_we) begin
         max_value_in  = value;
         max_holder_in = row;
      end
   end

   // value stores are written by the first valid row before any read
   always_ff @(posedge clock) begin
      min_value_ff  <= min_value_in;
      max_value_ff  <= max_value_in;
      min_holder_ff <= min_holder_in;
      max_holder_ff <= max_holder_in;
   end

   assign min_holder = min_holder_ff;
   assign max_holder = max_holder_ff;

endmodule

// ===== rtl/erf_merge.sv =====
// Merges lane compare flags: lowest active column wins, separately for min and max.
module erf_merge (
   input  logic                                 clock,
   input  logic                                 reset,
   input  erf_pkg::lane_flag_type               flag [erf_pkg::MAX_COLUMNS],
   input  logic [erf_pkg::MAX_COLUMNS-1:0]      active,
   input  logic                                 row_go,
   input  logic                                 first,
   output erf_pkg::lane_ctrl_type               ctrl [erf_pkg::MAX_COLUMNS]
);

   logic [erf_pkg::MAX_COLUMNS-1:0] lt_vec, gt_vec, min_grant, max_grant;

   always_comb begin
      for (int j = 0; j < erf_pkg::MAX_COLUMNS; j++) begin
         lt_vec[j] = flag[j].lt & active[j];
         gt_vec[j] = flag[j].gt & active[j];
      end
   end

   // isolate lowest set bit
   assign min_grant = lt_vec & (~lt_vec + 1'b1);
   assign max_grant = gt_vec & (~gt_vec + 1'b1);

   always_comb begin
      for (int j = 0; j < erf_pkg::MAX_COLUMNS; j++) begin
         ctrl[j].load   = row_go & first;
         ctrl[j].min_we = row_go & ~first & min_grant[j];
         ctrl[j].max_we = row_go & ~first & max_grant[j];
      end
   end

   a_min_grant_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(min_grant)) else $error("more than one min holder update");
   a_max_grant_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(max_grant)) else $error("more than one max holder update");
   a_grant_active: assert property (@(posedge clock) disable iff (reset)
      ((min_grant | max_grant) & ~active) == '0)
      else $error("update granted to a column not in use");

endmodule

// ===== rtl/extreme_row_finder_top.sv =====
// Extreme row finder top level: row intake, set state and result sequencer.
// Accepts one row per clock while a set is open; all columns are compared in
// parallel lanes and merged in the same cycle. A row with last_row set closes
// the set: the block then stops taking rows and emits one result per column
// in use, one per cycle while the result side is ready. The result sequencer
// reads one lane's holders per cycle through a single output register. Rows
// beyond the row limit are neither counted nor compared.
module extreme_row_finder_top (
   input  logic        clock,
   input  logic        reset,
   erf_req_if.sink     req_ch,
   erf_rsp_if.source   rsp_ch,
   erf_csr_if.sink     csr_ch
);

   localparam int NC = erf_pkg::MAX_COLUMNS;

   erf_pkg::state_type              state_ff, state_in;
   logic [erf_pkg::CFG_W-1:0]       cfg_ff, cfg_in;
   logic [erf_pkg::CFG_W-1:0]       ncol, ncol_ff, ncol_in;
   logic [NC-1:0]                   active;
   logic [erf_pkg::ROW_W-1:0]       row_count_ff, row_count_in;
   logic                            seen_valid_ff, seen_valid_in;
   logic [erf_pkg::COL_W-1:0]       emit_idx_ff, emit_idx_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [erf_pkg::COL_W-1:0]       column_index_ff, column_index_in;
   logic [erf_pkg::ROW_W-1:0]       min_row_ff, min_row_in;
   logic [erf_pkg::ROW_W-1:0]       max_row_ff, max_row_in;
   logic                            last_result_ff, last_result_in;

   logic                            req_fire, counting, row_go, last_fire;
   logic                            out_load, emit_done;
   logic signed [erf_pkg::VAL_W-1:0] values [NC];
   erf_pkg::lane_flag_type          flag [NC];
   erf_pkg::lane_ctrl_type          ctrl [NC];
   logic [erf_pkg::ROW_W-1:0]       min_holder [NC];
   logic [erf_pkg::ROW_W-1:0]       max_holder [NC];

   // configuration
   assign csr_ch.ready = 1'b1;
   assign cfg_in = (csr_ch.valid && csr_ch.ready) ? csr_ch.data : cfg_ff;

   always_comb begin
      if (cfg_ff == '0) begin
         ncol = erf_pkg::CFG_W'(1);
      end else if (cfg_ff > erf_pkg::CFG_W'(NC)) begin
         ncol = erf_pkg::CFG_W'(NC);
      end else begin
         ncol = cfg_ff;
      end
      for (int j = 0; j < NC; j++) begin
         active[j] = erf_pkg::CFG_W'(j) < ncol;
      end
   end

   assign values[0] = req_ch.value_0;
   assign values[1] = req_ch.value_1;
   assign values[2] = req_ch.value_2;
   assign values[3] = req_ch.value_3;
   assign values[4] = req_ch.value_4;
   assign values[5] = req_ch.value_5;
   assign values[6] = req_ch.value_6;
   assign values[7] = req_ch.value_7;

   // outputs of the state machine
   always_comb begin
      req_ch.ready = state_ff == erf_pkg::ST_ROWS;
      out_load     = (state_ff == erf_pkg::ST_EMIT) && (!rsp_valid_ff || rsp_ch.ready);
      emit_done    = out_load &&
                     ({1'b0, emit_idx_ff} + erf_pkg::CFG_W'(1)) == ncol_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         erf_pkg::ST_ROWS: begin
            if (last_fire) state_in = erf_pkg::ST_EMIT;
         end
         erf_pkg::ST_EMIT: begin
            if (emit_done) state_in = erf_pkg::ST_ROWS;
         end
         default: state_in = erf_pkg::ST_ROWS;
      endcase
   end

   assign req_fire  = req_ch.valid && req_ch.ready;
   assign counting  = row_count_ff < erf_pkg::ROW_W'(erf_pkg::MAX_ROWS);
   assign row_go    = req_fire && counting && req_ch.row_valid;
   assign last_fire = req_fire && req_ch.last_row;

   genvar g;
   generate
      for (g = 0; g < NC; g++) begin : g_lane
         erf_lane u_lane (
            .clock      (clock),
            .value      (values[g]),
            .row        (row_count_ff),
            .ctrl       (ctrl[g]),
            .flag       (flag[g]),
            .min_holder (min_holder[g]),
            .max_holder (max_holder[g])
         );
      end
   endgenerate

   erf_merge u_merge (
      .clock  (clock),
      .reset  (reset),
      .flag   (flag),
      .active (active),
      .row_go (row_go),
      .first  (!seen_valid_ff),
      .ctrl   (ctrl)
   );

   // set state
   always_comb begin
      row_count_in  = row_count_ff;
      seen_valid_in = seen_valid_ff;
      ncol_in       = ncol_ff;
      emit_idx_in   = emit_idx_ff;
      if (req_fire && counting) row_count_in = row_count_ff + 1'b1;
      if (row_go) seen_valid_in = 1'b1;
      if (last_fire) begin
         ncol_in     = ncol;
         emit_idx_in = '0;
      end
      if (out_load) emit_idx_in = emit_idx_ff + 1'b1;
      if (emit_done) begin
         row_count_in  = '0;
         seen_valid_in = 1'b0;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in    = rsp_valid_ff && !rsp_ch.ready;
      column_index_in = column_index_ff;
      min_row_in      = min_row_ff;
      max_row_in      = max_row_ff;
      last_result_in  = last_result_ff;
      if (out_load) begin
         rsp_valid_in    = 1'b1;
         column_index_in = emit_idx_ff;
         min_row_in      = seen_valid_ff ? min_holder[emit_idx_ff] : row_count_ff;
         max_row_in      = seen_valid_ff ? max_holder[emit_idx_ff] : row_count_ff;
         last_result_in  = emit_done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= erf_pkg::ST_ROWS;
         cfg_ff        <= erf_pkg::CFG_RESET;
         ncol_ff       <= erf_pkg::CFG_RESET;
         row_count_ff  <= '0;
         seen_valid_ff <= 1'b0;
         emit_idx_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cfg_ff        <= cfg_in;
         ncol_ff       <= ncol_in;
         row_count_ff  <= row_count_in;
         seen_valid_ff <= seen_valid_in;
         emit_idx_ff   <= emit_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      column_index_ff <= column_index_in;
      min_row_ff      <= min_row_in;
      max_row_ff      <= max_row_in;
      last_result_ff  <= last_result_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.column_index = column_index_ff;
   assign rsp_ch.min_row      = min_row_ff;
   assign rsp_ch.max_row      = max_row_ff;
   assign rsp_ch.last_result  = last_result_ff;

   a_no_rows_in_emit: assert property (@(posedge clock) disable iff (reset)
      state_ff == erf_pkg::ST_EMIT |-> !req_ch.ready)
      else $error("row taken while results are being emitted");
   a_emit_idx_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == erf_pkg::ST_EMIT |-> {1'b0, emit_idx_ff} < ncol_ff)
      else $error("emit index beyond columns in use");
   a_set_cleared: assert property (@(posedge clock) disable iff (reset)
      emit_done |=> (row_count_ff == '0) && !seen_valid_ff)
      else $error("set state not cleared after final result");
   a_row_limit: assert property (@(posedge clock) disable iff (reset)
      row_count_ff <= erf_pkg::ROW_W'(erf_pkg::MAX_ROWS))
      else $error("row count beyond limit");

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the extreme row finder: directed table, random sets, scoreboard.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD     = 10;
   localparam int RESET_CYCLES   = 5;
   localparam int SETTLE_CYCLES  = 8;
   localparam int END_CYCLES     = 20;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_PHASES  = 14;
   localparam int PHASE_ROWS     = 28;
   localparam int NUM_DIRECTED   = 17;

   localparam logic signed [erf_pkg::VAL_W-1:0] VMIN = 32'sh8000_0000;
   localparam logic signed [erf_pkg::VAL_W-1:0] VMAX = 32'sh7FFF_FFFF;

   typedef struct {
      logic                             row_valid;
      logic signed [erf_pkg::VAL_W-1:0] val [erf_pkg::MAX_COLUMNS];
      logic                             last_row;
   } row_type;

   typedef struct {
      logic [erf_pkg::COL_W-1:0] col;
      logic [erf_pkg::ROW_W-1:0] min_row;
      logic [erf_pkg::ROW_W-1:0] max_row;
      logic                      last_result;
   } extreme_result_type;

   // optional hand-computed holders for the set a last row closes
   typedef struct {
      bit typed;
      int exp_min;
      int exp_max;
   } row_note_type;

   typedef struct {
      bit                               vld;
      bit                               lst;
      logic signed [erf_pkg::VAL_W-1:0] base;
      int                               alt_col;
      logic signed [erf_pkg::VAL_W-1:0] alt;
      bit                               typed;
      int                               exp_min;
      int                               exp_max;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset;

   erf_req_if req_ch ();
   erf_rsp_if rsp_ch ();
   erf_csr_if csr_ch ();

   extreme_row_finder_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // predictor state
   logic [erf_pkg::CFG_W-1:0]        cols_cfg;
   int                               rows_seen;
   bit                               have_valid;
   logic [erf_pkg::ROW_W-1:0]        min_holder_row [erf_pkg::MAX_COLUMNS];
   logic [erf_pkg::ROW_W-1:0]        max_holder_row [erf_pkg::MAX_COLUMNS];
   logic signed [erf_pkg::VAL_W-1:0] held_min [erf_pkg::MAX_COLUMNS];
   logic signed [erf_pkg::VAL_W-1:0] held_max [erf_pkg::MAX_COLUMNS];

   extreme_result_type awaited_results [$];
   row_note_type       row_notes [$];
   int                 errors;
   int                 idle_cycles;
   int                 stall_left;
   bit                 req_burst;
   bit                 rsp_burst;

   plan_row_type directed_plan [NUM_DIRECTED] = '{
      '{0, 1, 0,    -1, 0,    1, 1, 1},   // lone skipped row: holders read row count
      '{1, 1, VMAX, -1, 0,    1, 0, 0},
      '{1, 0, VMIN, -1, 0,    0, 0, 0},
      '{1, 1, VMIN, -1, 0,    1, 0, 0},   // equal values never take over
      '{1, 0, 0,    -1, 0,    0, 0, 0},
      '{1, 0, 0,     0, VMAX, 0, 0, 0},
      '{1, 0, 0,     0, VMIN, 0, 0, 0},
      '{1, 0, 0,     5, -5,   0, 0, 0},
      '{1, 1, 0,     7, 9,    0, 0, 0},
      '{0, 0, VMAX, -1, 0,    0, 0, 0},
      '{0, 0, VMIN, -1, 0,    0, 0, 0},
      '{1, 0, 3,    -1, 0,    0, 0, 0},
      '{0, 1, -7,   -1, 0,    1, 2, 2},
      '{1, 0, 100,  -1, 0,    0, 0, 0},
      '{1, 0, -100, -1, 0,    0, 0, 0},   // only the lowest column moves
      '{1, 0, -200, -1, 0,    0, 0, 0},
      '{1, 1, 200,  -1, 0,    0, 0, 0}
   };

   function automatic void clear_extremes();
      rows_seen  = 0;
      have_valid = 0;
      for (int j = 0; j < erf_pkg::MAX_COLUMNS; j++) begin
         min_holder_row[j] = '0;
         max_holder_row[j] = '0;
      end
   endfunction

   // one row through the predictor; returns the number of results it closes out
   function automatic int advance_extremes(input row_type r,
                                           output extreme_result_type res [erf_pkg::MAX_COLUMNS]);
      int ncol;
      bit min_done;
      bit max_done;
      ncol     = (cols_cfg == 0) ? 1 :
                 (cols_cfg > erf_pkg::MAX_COLUMNS) ? erf_pkg::MAX_COLUMNS : int'(cols_cfg);
      min_done = 0;
      max_done = 0;
      if (rows_seen < erf_pkg::MAX_ROWS) begin
         if (r.row_valid && !have_valid) begin
            for (int j = 0; j < erf_pkg::MAX_COLUMNS; j++) begin
               held_min[j]       = r.val[j];
               held_max[j]       = r.val[j];
               min_holder_row[j] = erf_pkg::ROW_W'(rows_seen);
               max_holder_row[j] = erf_pkg::ROW_W'(rows_seen);
            end
            have_valid = 1;
         end else if (r.row_valid) begin
            for (int j = 0; j < ncol; j++) begin
               if (!min_done && r.val[j] < held_min[j]) begin
                  held_min[j]       = r.val[j];
                  min_holder_row[j] = erf_pkg::ROW_W'(rows_seen);
                  min_done          = 1;
               end
               if (!max_done && r.val[j] > held_max[j]) begin
                  held_max[j]       = r.val[j];
                  max_holder_row[j] = erf_pkg::ROW_W'(rows_seen);
                  max_done          = 1;
               end
            end
         end
         rows_seen++;
      end
      if (!r.last_row)
         return 0;
      for (int j = 0; j < ncol; j++) begin
         res[j].col         = erf_pkg::COL_W'(j);
         res[j].min_row     = have_valid ? min_holder_row[j] : erf_pkg::ROW_W'(rows_seen);
         res[j].max_row     = have_valid ? max_holder_row[j] : erf_pkg::ROW_W'(rows_seen);
         res[j].last_result = (j + 1 == ncol);
      end
      clear_extremes();
      return ncol;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   function automatic logic signed [erf_pkg::VAL_W-1:0] pick_value();
      case ($urandom_range(0, 5))
         0: return VMIN;
         1: return VMAX;
         2, 3: return erf_pkg::VAL_W'(int'($urandom_range(0, 8)) - 4);   // dense range for ties
         default: return $urandom;
      endcase
   endfunction

   task automatic send_row(input row_type r, input row_note_type note);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      row_notes.push_back(note);
      req_ch.valid     <= 1'b1;
      req_ch.row_valid <= r.row_valid;
      req_ch.value_0   <= r.val[0];
      req_ch.value_1   <= r.val[1];
      req_ch.value_2   <= r.val[2];
      req_ch.value_3   <= r.val[3];
      req_ch.value_4   <= r.val[4];
      req_ch.value_5   <= r.val[5];
      req_ch.value_6   <= r.val[6];
      req_ch.value_7   <= r.val[7];
      req_ch.last_row  <= r.last_row;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_set(input int len, input int valid_pct);
      row_type      r;
      row_note_type note;
      note = '{0, 0, 0};
      for (int i = 0; i < len; i++) begin
         r.row_valid = ($urandom_range(0, 99) < valid_pct);
         for (int j = 0; j < erf_pkg::MAX_COLUMNS; j++)
            r.val[j] = pick_value();
         r.last_row = (i == len - 1);
         send_row(r, note);
      end
   endtask

   // hold rows back until every pending result has been taken
   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (awaited_results.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_cols(input logic [erf_pkg::CFG_W-1:0] v);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= v;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (rsp_ch.valid && rsp_ch.ready)
         stall_left = rsp_burst ? 0 : $urandom_range(0, 5);
      else if (stall_left > 0)
         stall_left = stall_left - 1;
      else if (!rsp_burst && $urandom_range(0, 7) == 0)
         stall_left = $urandom_range(1, 5);
      rsp_ch.ready <= (stall_left == 0);
   end

   always @(posedge clock) begin : monitor
      row_type            r;
      row_note_type       note;
      extreme_result_type res [erf_pkg::MAX_COLUMNS];
      extreme_result_type want;
      int                 n;
      bit                 moved;
      moved = 0;
      if (!reset) begin
         if (csr_ch.valid && csr_ch.ready) begin
            cols_cfg = csr_ch.data;
            moved    = 1;
         end
         if (req_ch.valid && req_ch.ready) begin
            r.row_valid = req_ch.row_valid;
            r.val[0]    = req_ch.value_0;
            r.val[1]    = req_ch.value_1;
            r.val[2]    = req_ch.value_2;
            r.val[3]    = req_ch.value_3;
            r.val[4]    = req_ch.value_4;
            r.val[5]    = req_ch.value_5;
            r.val[6]    = req_ch.value_6;
            r.val[7]    = req_ch.value_7;
            r.last_row  = req_ch.last_row;
            note        = row_notes.pop_front();
            n           = advance_extremes(r, res);
            for (int j = 0; j < n; j++) begin
               if (note.typed) begin
                  res[j].min_row = erf_pkg::ROW_W'(note.exp_min);
                  res[j].max_row = erf_pkg::ROW_W'(note.exp_max);
               end
               awaited_results.push_back(res[j]);
            end
            moved = 1;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual column %0d", $time,
                        rsp_ch.column_index);
               errors++;
            end else begin
               want = awaited_results.pop_front();
               check_field("column_index", 16'(want.col), 16'(rsp_ch.column_index));
               check_field("min_row", 16'(want.min_row), 16'(rsp_ch.min_row));
               check_field("max_row", 16'(want.max_row), 16'(rsp_ch.max_row));
               check_field("last_result", 16'(want.last_result), 16'(rsp_ch.last_result));
            end
            moved = 1;
         end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog, no transfer for %0d cycles", $time, idle_cycles);
         $display("tb_top: done, errors");
         $finish;
      end
   end

   initial begin
      row_type                   r;
      row_note_type              note;
      logic [erf_pkg::CFG_W-1:0] cfg_sweep [6];
      int                        len;

      cfg_sweep = '{4'd1, 4'd15, 4'd0, 4'd8, 4'd9, 4'd3};
      errors      = 0;
      idle_cycles = 0;
      stall_left  = 0;
      req_burst   = 0;
      rsp_burst   = 0;
      cols_cfg    = erf_pkg::CFG_RESET;
      clear_extremes();

      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.row_valid = 1'b0;
      req_ch.value_0   = '0;
      req_ch.value_1   = '0;
      req_ch.value_2   = '0;
      req_ch.value_3   = '0;
      req_ch.value_4   = '0;
      req_ch.value_5   = '0;
      req_ch.value_6   = '0;
      req_ch.value_7   = '0;
      req_ch.last_row  = 1'b0;
      rsp_ch.ready     = 1'b0;
      csr_ch.valid     = 1'b0;
      csr_ch.data      = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed rows run at the reset column count
      foreach (directed_plan[i]) begin
         r.row_valid = directed_plan[i].vld;
         r.last_row  = directed_plan[i].lst;
         for (int j = 0; j < erf_pkg::MAX_COLUMNS; j++)
            r.val[j] = (j == directed_plan[i].alt_col) ? directed_plan[i].alt
                                                       : directed_plan[i].base;
         note = '{directed_plan[i].typed, directed_plan[i].exp_min, directed_plan[i].exp_max};
         send_row(r, note);
      end

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         drain();
         write_cols(p < 6 ? cfg_sweep[p] : erf_pkg::CFG_W'($urandom_range(0, 15)));
         req_burst = ($urandom_range(0, 3) == 0);
         rsp_burst = ($urandom_range(0, 3) == 0);
         len = 0;
         while (len < PHASE_ROWS) begin
            n_rows_block : begin
               int set_len;
               set_len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 12);
               send_set(set_len, ($urandom_range(0, 9) == 0) ? 0 : 88);
               len += set_len;
            end
         end
      end

      req_ch.valid <= 1'b0;
      do @(posedge clock); while (awaited_results.size() != 0);
      repeat (END_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/erf_pkg.sv
rtl/erf_if.sv
rtl/erf_lane.sv
rtl/erf_merge.sv
rtl/extreme_row_finder_top.sv
sim/tb_top.sv
